// ===== hdl/ile_pkg.sv =====
`timescale 1ns / 1ps

package ile_pkg;

	// command codes on the mode field
	typedef enum logic [2:0] {
		MODE_APPEND  = 3'd0,
		MODE_PREPEND = 3'd1,
		MODE_INSERT  = 3'd2,
		MODE_REMOVE  = 3'd3,
		MODE_FIND    = 3'd4,
		MODE_READ    = 3'd5,
		MODE_WRITE   = 3'd6,
		MODE_CLEAR   = 3'd7
	} mode_t;

	// result codes on the status field
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// what every cell does with its entry
	typedef enum logic [1:0] {
		ACT_HOLD   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_WRITE  = 2'd3
	} act_t;

endpackage

// ===== hdl/indexed_list_engine.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake               payload
// in       input      in_valid / in_ready     mode, index, value
// out      output     out_valid / out_ready   status, read_value, found_index, count
//
// a command is taken into the cell chain on its transfer cycle; the chain shifts,
// loads or holds all entries at once, so an edit takes effect at the end of its transfer cycle
// the result passes the search/read stage and then the result register before it shows on out
// sustained rate one command per cycle while out_ready stays high
// in_ready drops only while the search/read stage holds a result that cannot move on
// reset clears the entry count and both valid flags; entry data stay undefined

module indexed_list_engine #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       mode,
	input  logic [$clog2(DEPTH)-1:0]         index,
	input  logic [DATA_W-1:0]                value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic [DATA_W-1:0]                read_value,
	output logic [$clog2(DEPTH)-1:0]         found_index,
	output logic [$clog2(DEPTH+1)-1:0]       count
);

	localparam int POS_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	// live entry count
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nx;

	// command decode for the chain
	ile_pkg::act_t    act;
	logic [POS_W-1:0] act_pos;
	ile_pkg::status_t st_nx;
	logic [CNT_W-1:0] idx_ext;
	logic             is_full;
	logic             is_bad;

	// search/read stage
	logic                  s1_valid_q;
	ile_pkg::mode_t        mode_s1;
	logic [POS_W-1:0]      index_s1;
	logic [DATA_W-1:0]     value_s1;
	ile_pkg::status_t      status_s1;
	logic [CNT_W-1:0]      count_s1;

	// result register
	logic                  out_valid_q;
	ile_pkg::status_t      status_q;
	logic [DATA_W-1:0]     read_value_q;
	logic [POS_W-1:0]      found_index_q;
	logic [CNT_W-1:0]      count_q;

	logic in_fire;
	logic out_load;

	// chain wiring
	logic [DATA_W-1:0] entry_w [DEPTH];
	logic [DEPTH-1:0]  match_w;

	logic              hit;
	logic [POS_W-1:0]  first_pos;
	logic [DATA_W-1:0] sel_entry;

	ile_pkg::status_t  res_status;
	logic [DATA_W-1:0] res_read;
	logic [POS_W-1:0]  res_found;

	// the stage can take a new command whenever its current one moves on
	assign out_load = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || out_load;
	assign in_fire  = in_valid && in_ready;

	// decide status, new count and cell action from the command and the count; action and count hold without a transfer
	always_comb begin
		idx_ext = CNT_W'(index);
		is_full = (cnt_q == FULL_CNT);
		is_bad  = (idx_ext >= cnt_q);
		act     = ile_pkg::ACT_HOLD;
		act_pos = '0;
		st_nx   = ile_pkg::ST_OK;
		cnt_nx  = cnt_q;
		unique case (ile_pkg::mode_t'(mode))
			ile_pkg::MODE_APPEND: begin
				if (is_full) begin
					st_nx = ile_pkg::ST_FULL;
				end else begin
					// append is an insert just past the last live entry
					act     = ile_pkg::ACT_INSERT;
					act_pos = POS_W'(cnt_q);
					cnt_nx  = cnt_q + 1'b1;
				end
			end
			ile_pkg::MODE_PREPEND: begin
				if (is_full) begin
					st_nx = ile_pkg::ST_FULL;
				end else begin
					act     = ile_pkg::ACT_INSERT;
					act_pos = '0;
					cnt_nx  = cnt_q + 1'b1;
				end
			end
			ile_pkg::MODE_INSERT: begin
				// index check takes priority over the full check
				priority if (is_bad) begin
					st_nx = ile_pkg::ST_BAD_INDEX;
				end else if (is_full) begin
					st_nx = ile_pkg::ST_FULL;
				end else begin
					act     = ile_pkg::ACT_INSERT;
					act_pos = index;
					cnt_nx  = cnt_q + 1'b1;
				end
			end
			ile_pkg::MODE_REMOVE: begin
				if (is_bad) begin
					st_nx = ile_pkg::ST_BAD_INDEX;
				end else begin
					act     = ile_pkg::ACT_REMOVE;
					act_pos = index;
					cnt_nx  = cnt_q - 1'b1;
				end
			end
			ile_pkg::MODE_FIND: begin
				// settled in the search stage
				st_nx = ile_pkg::ST_NOT_FOUND;
			end
			ile_pkg::MODE_READ: begin
				if (is_bad) begin
					st_nx = ile_pkg::ST_BAD_INDEX;
				end
			end
			ile_pkg::MODE_WRITE: begin
				if (is_bad) begin
					st_nx = ile_pkg::ST_BAD_INDEX;
				end else begin
					act     = ile_pkg::ACT_WRITE;
					act_pos = index;
				end
			end
			ile_pkg::MODE_CLEAR: begin
				// entry data are left in place
				cnt_nx = '0;
			end
			default: begin
				st_nx = ile_pkg::ST_OK;
			end
		endcase
		if (!in_fire) begin
			act    = ile_pkg::ACT_HOLD;
			cnt_nx = cnt_q;
		end
	end

	// row of entry cells, each handing its entry to its neighbours
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = entry_w[g];
		end else begin : g_left
			assign left_w = entry_w[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_w = entry_w[g];
		end else begin : g_right
			assign right_w = entry_w[g+1];
		end

		ile_cell #(
			.DATA_W (DATA_W),
			.POS_W  (POS_W),
			.CNT_W  (CNT_W),
			.POS    (g)
		) u_cell (
			.clk         (clk),
			.act         (act),
			.pos         (act_pos),
			.load_value  (value),
			.left_entry  (left_w),
			.right_entry (right_w),
			.key         (value_s1),
			.live_count  (cnt_q),
			.entry       (entry_w[g]),
			.match       (match_w[g])
		);
	end

	// search and read over the chain as it stands after the staged command
	ile_pick #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W),
		.POS_W  (POS_W)
	) u_pick (
		.match     (match_w),
		.entry     (entry_w),
		.sel       (index_s1),
		.hit       (hit),
		.first_pos (first_pos),
		.sel_entry (sel_entry)
	);

	// finish the result in the search stage
	always_comb begin
		res_status = status_s1;
		res_read   = '0;
		res_found  = '0;
		unique case (mode_s1)
			ile_pkg::MODE_FIND: begin
				if (hit) begin
					res_status = ile_pkg::ST_OK;
					res_found  = first_pos;
				end
			end
			ile_pkg::MODE_READ: begin
				if (status_s1 == ile_pkg::ST_OK) begin
					res_read = sel_entry;
				end
			end
			default: begin
				res_status = status_s1;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nx;
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (out_load) begin
				s1_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1   <= ile_pkg::mode_t'(mode);
			index_s1  <= index;
			value_s1  <= value;
			status_s1 <= st_nx;
			count_s1  <= cnt_nx;
		end
		if (out_load) begin
			status_q      <= res_status;
			read_value_q  <= res_read;
			found_index_q <= res_found;
			count_q       <= count_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign found_index = found_index_q;
	assign count       = count_q;

	// the list never holds more than its depth
	a_cnt_bound : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count above depth");

	// a transfer in always lands in the search stage
	a_stage_fill : assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> s1_valid_q)
		else $error("accepted command lost before search stage");

	// a full report only comes from a full list
	a_full_count : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ile_pkg::ST_FULL)) |-> (count == FULL_CNT))
		else $error("full status with spare room");

	// the count moves only on a transfer in
	a_cnt_moves : assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(in_fire))
		else $error("entry count changed without a command");

endmodule

// ===== hdl/ile_cell.sv =====
`timescale 1ns / 1ps

module ile_cell #(
	parameter int DATA_W = 32,
	parameter int POS_W  = 4,
	parameter int CNT_W  = 5,
	parameter int POS    = 0
) (
	input  logic                clk,
	input  ile_pkg::act_t       act,
	input  logic [POS_W-1:0]    pos,
	input  logic [DATA_W-1:0]   load_value,
	input  logic [DATA_W-1:0]   left_entry,
	input  logic [DATA_W-1:0]   right_entry,
	input  logic [DATA_W-1:0]   key,
	input  logic [CNT_W-1:0]    live_count,
	output logic [DATA_W-1:0]   entry,
	output logic                match
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(POS);

	logic [DATA_W-1:0] entry_q;
	logic [DATA_W-1:0] entry_nx;

	// next entry: load, take from a neighbour or keep
	always_comb begin
		entry_nx = entry_q;
		unique case (act)
			ile_pkg::ACT_INSERT: begin
				// cells below the insert position keep their entry
				if (MY_POS == pos) begin
					entry_nx = load_value;
				end else if (MY_POS > pos) begin
					entry_nx = left_entry;
				end
			end
			ile_pkg::ACT_REMOVE: begin
				if (MY_POS >= pos) begin
					entry_nx = right_entry;
				end
			end
			ile_pkg::ACT_WRITE: begin
				if (MY_POS == pos) begin
					entry_nx = load_value;
				end
			end
			default: begin
				entry_nx = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nx;
	end

	assign entry = entry_q;
	// only a live position may answer a search
	assign match = (entry_q == key) && (MY_CNT < live_count);

endmodule

// ===== hdl/ile_pick.sv =====
`timescale 1ns / 1ps

module ile_pick #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32,
	parameter int POS_W  = 4
) (
	input  logic [DEPTH-1:0]  match,
	input  logic [DATA_W-1:0] entry [DEPTH],
	input  logic [POS_W-1:0]  sel,
	output logic              hit,
	output logic [POS_W-1:0]  first_pos,
	output logic [DATA_W-1:0] sel_entry
);

	// lowest matching position wins
	always_comb begin
		hit       = 1'b0;
		first_pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit       = 1'b1;
				first_pos = POS_W'(i);
			end
		end
	end

	assign sel_entry = entry[sel];

endmodule
